### rtl/ppi_pkg.sv
// Shared types and constants for the particle pool integrator.
// Holds the transaction payload structs and the per-slot record kept in the slot memory.
// No dependencies.
`default_nettype none

package ppi_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int MAX_RESULTS    = 64;
  localparam int Q_W            = 32;
  localparam int LIFE_W         = 16;
  localparam int SLOT_W         = 6;

  localparam logic CMD_SPAWN   = 1'b0;
  localparam logic CMD_TICK    = 1'b1;
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [Q_W-1:0]   in_pos_x;
    logic signed [Q_W-1:0]   in_pos_y;
    logic signed [Q_W-1:0]   in_pos_z;
    logic signed [Q_W-1:0]   in_vel_x;
    logic signed [Q_W-1:0]   in_vel_y;
    logic signed [Q_W-1:0]   in_vel_z;
    logic signed [Q_W-1:0]   in_acc_x;
    logic signed [Q_W-1:0]   in_acc_y;
    logic signed [Q_W-1:0]   in_acc_z;
    logic [LIFE_W-1:0]       lifetime;
  } ppi_in_t;

  typedef struct packed {
    logic                    kind;
    logic                    accepted;
    logic [SLOT_W-1:0]       slot;
    logic signed [Q_W-1:0]   out_pos_x;
    logic signed [Q_W-1:0]   out_pos_y;
    logic signed [Q_W-1:0]   out_pos_z;
    logic                    last;
  } ppi_out_t;

  // One pool entry as stored in the slot memory.
  typedef struct packed {
    logic signed [Q_W-1:0]   pos_x;
    logic signed [Q_W-1:0]   pos_y;
    logic signed [Q_W-1:0]   pos_z;
    logic signed [Q_W-1:0]   vel_x;
    logic signed [Q_W-1:0]   vel_y;
    logic signed [Q_W-1:0]   vel_z;
    logic signed [Q_W-1:0]   acc_x;
    logic signed [Q_W-1:0]   acc_y;
    logic signed [Q_W-1:0]   acc_z;
    logic [LIFE_W-1:0]       countdown;
  } slot_rec_t;

endpackage

`default_nettype wire

### rtl/particle_pool_integrator_core.sv
// Spawn: scans live flags from slot 0, one slot per cycle; if no slot is free the result is a
// rejection, and the next transaction can be taken once the result is in the output register.
// Tick: streams the slot memory one entry per cycle (read, update, write back) while the result
// channel does not stall; the last reported survivor is flagged as the final result.
// One transaction is processed at a time; the output register lets the next one be taken
// while the final result still waits. Reset (rst_n, synchronous) clears all live flags.
// Depends on ppi_pkg.
`default_nettype none

module particle_pool_integrator_core #(
  parameter int SLOT_COUNT = ppi_pkg::SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppi_pkg::ppi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppi_pkg::ppi_out_t out_data
);
  import ppi_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SPAWN, S_TICK, S_FLUSH} state_t;

  state_t                 state_r;
  ppi_in_t                req_r;
  logic [SLOT_COUNT-1:0]  live_r;
  logic [IDX_W-1:0]       scan_r;
  logic [CNT_W-1:0]       rd_cnt_r;
  logic                   s1_v_r;
  logic                   s1_live_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic                   p_v_r;
  ppi_out_t               p_data_r;
  logic [RES_W-1:0]       rep_cnt_r;
  logic                   out_valid_r;
  ppi_out_t               out_data_r;

  slot_rec_t              mem [SLOT_COUNT];
  slot_rec_t              rd_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  slot_rec_t              mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;

  logic                   o_free;
  logic                   out_load;
  logic                   spawn_free;
  logic                   spawn_hit;
  logic                   issue_left;
  logic                   cd_zero;
  logic                   report;
  logic                   s1_done;
  logic                   advance;
  slot_rec_t              upd_rec;
  slot_rec_t              spawn_rec;
  ppi_out_t               report_res;
  ppi_out_t               spawn_res;
  ppi_out_t               flush_res;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign o_free     = !out_valid_r || out_ready;
  assign spawn_free = !live_r[scan_r];
  assign spawn_hit  = spawn_free || (scan_r == IDX_W'(SLOT_COUNT - 1));
  assign issue_left = (rd_cnt_r != CNT_W'(SLOT_COUNT));
  assign cd_zero    = (rd_q.countdown == '0);
  assign report     = s1_live_r && !cd_zero && (rep_cnt_r != RES_W'(MAX_RESULTS));
  // A reported survivor pushes the held one out, which needs room in the output register.
  assign s1_done    = !s1_v_r || !report || !p_v_r || o_free;
  assign advance    = (state_r == S_TICK) && s1_done;
  assign out_load   = (state_r == S_SPAWN && spawn_hit && o_free) ||
                      (advance && s1_v_r && report && p_v_r) ||
                      (state_r == S_FLUSH && p_v_r && o_free);

  always_comb begin
    upd_rec           = rd_q;
    upd_rec.vel_x     = rd_q.vel_x + rd_q.acc_x;
    upd_rec.vel_y     = rd_q.vel_y + rd_q.acc_y;
    upd_rec.vel_z     = rd_q.vel_z + rd_q.acc_z;
    upd_rec.pos_x     = rd_q.pos_x + upd_rec.vel_x;
    upd_rec.pos_y     = rd_q.pos_y + upd_rec.vel_y;
    upd_rec.pos_z     = rd_q.pos_z + upd_rec.vel_z;
    upd_rec.countdown = rd_q.countdown - LIFE_W'(1);

    spawn_rec.pos_x     = req_r.in_pos_x;
    spawn_rec.pos_y     = req_r.in_pos_y;
    spawn_rec.pos_z     = req_r.in_pos_z;
    spawn_rec.vel_x     = req_r.in_vel_x;
    spawn_rec.vel_y     = req_r.in_vel_y;
    spawn_rec.vel_z     = req_r.in_vel_z;
    spawn_rec.acc_x     = req_r.in_acc_x;
    spawn_rec.acc_y     = req_r.in_acc_y;
    spawn_rec.acc_z     = req_r.in_acc_z;
    spawn_rec.countdown = req_r.lifetime;

    report_res.kind      = KIND_REPORT;
    report_res.accepted  = 1'b1;
    report_res.slot      = SLOT_W'(s1_idx_r);
    report_res.out_pos_x = upd_rec.pos_x;
    report_res.out_pos_y = upd_rec.pos_y;
    report_res.out_pos_z = upd_rec.pos_z;
    report_res.last      = 1'b0;

    spawn_res.kind = KIND_ACK;
    spawn_res.last = 1'b1;
    if (spawn_free) begin
      spawn_res.accepted  = 1'b1;
      spawn_res.slot      = SLOT_W'(scan_r);
      spawn_res.out_pos_x = req_r.in_pos_x;
      spawn_res.out_pos_y = req_r.in_pos_y;
      spawn_res.out_pos_z = req_r.in_pos_z;
    end else begin
      spawn_res.accepted  = 1'b0;
      spawn_res.slot      = '0;
      spawn_res.out_pos_x = '0;
      spawn_res.out_pos_y = '0;
      spawn_res.out_pos_z = '0;
    end

    flush_res      = p_data_r;
    flush_res.last = 1'b1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_r;
    mem_wdata = spawn_rec;
    if (state_r == S_SPAWN && spawn_hit && spawn_free && o_free) begin
      mem_we = 1'b1;
    end else if (advance && s1_v_r && s1_live_r) begin
      mem_we    = 1'b1;
      mem_waddr = s1_idx_r;
      mem_wdata = upd_rec;
    end
    mem_re    = advance && issue_left;
    mem_raddr = rd_cnt_r[IDX_W-1:0];
  end

  // Slot memory: one write port, one read port, registered read data held while idle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      s1_v_r      <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r     <= in_data;
            scan_r    <= '0;
            rd_cnt_r  <= '0;
            rep_cnt_r <= '0;
            s1_v_r    <= 1'b0;
            p_v_r     <= 1'b0;
            state_r   <= (in_data.cmd == CMD_TICK) ? S_TICK : S_SPAWN;
          end
        end
        S_SPAWN: begin
          if (spawn_hit) begin
            if (o_free) begin
              out_data_r <= spawn_res;
              if (spawn_free) begin
                live_r[scan_r] <= 1'b1;
              end
              state_r <= S_IDLE;
            end
          end else begin
            scan_r <= scan_r + IDX_W'(1);
          end
        end
        S_TICK: begin
          if (advance) begin
            s1_v_r <= issue_left;
            if (issue_left) begin
              s1_idx_r  <= rd_cnt_r[IDX_W-1:0];
              s1_live_r <= live_r[rd_cnt_r[IDX_W-1:0]];
              rd_cnt_r  <= rd_cnt_r + CNT_W'(1);
            end
            if (s1_v_r && s1_live_r && cd_zero) begin
              live_r[s1_idx_r] <= 1'b0;
            end
            // The newest survivor is held back until it is known whether it is the final one.
            if (s1_v_r && report) begin
              if (p_v_r) begin
                out_data_r <= p_data_r;
              end
              p_data_r  <= report_res;
              p_v_r     <= 1'b1;
              rep_cnt_r <= rep_cnt_r + RES_W'(1);
            end
            if (!issue_left && !s1_v_r) begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!p_v_r) begin
            state_r <= S_IDLE;
          end else if (o_free) begin
            out_data_r <= flush_res;
            p_v_r      <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
